// ===== src/card_mark_table_engine_macros.svh =====
// Assertion macros for the card mark table engine checker.
// No dependencies.
`ifndef CARD_MARK_TABLE_ENGINE_MACROS_SVH
`define CARD_MARK_TABLE_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CMTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked at every edge, reset included.
`define CMTE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/cmte_pkg.sv =====
// Package for the card mark table engine: command codes and front-to-back word.
// No dependencies.
`default_nettype none
package cmte_pkg;
  localparam logic [1:0] CMD_MARK  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  // Classified command handed from front to back
  typedef struct packed {
    logic        do_range;   // mark or clear with valid range
    logic        set;        // 1 mark, 0 clear
    logic        do_scan;    // scan inside heap
    logic        err;        // start after end
    logic [23:0] lo;
    logic [23:0] hi;
    logic        reloc;
  } cmd_word_t;
endpackage
`default_nettype wire

// ===== src/cmte_front.sv =====
// Front end: accepts input words, classifies them, clips ranges to the heap.
// Depends on cmte_pkg.
`default_nettype none
module cmte_front #(
  parameter int HEAP_WORDS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [15:0]       in_start_word,
  input  wire logic [15:0]       in_end_word,
  input  wire logic              in_relocating,
  output logic                   q_valid,
  output cmte_pkg::cmd_word_t    q_word,
  input  wire logic              q_take
);
  localparam logic [24:0] HW = 25'(HEAP_WORDS);
  localparam int QD = 2;

  cmte_pkg::cmd_word_t q_r [QD];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  cmte_pkg::cmd_word_t cls;
  logic push_ok, take_ok;

  // classify
  always_comb begin
    cls = '0;
    cls.lo = 24'(in_start_word);
    cls.hi = (25'(in_end_word) >= HW) ? 24'(HW - 25'd1) : 24'(in_end_word);
    cls.reloc = in_relocating;
    cls.set = (in_cmd == cmte_pkg::CMD_MARK);
    if (in_cmd == cmte_pkg::CMD_MARK || in_cmd == cmte_pkg::CMD_CLEAR) begin
      if (in_start_word > in_end_word) cls.err = 1'b1;
      else cls.do_range = (25'(in_start_word) < HW);
    end else if (in_cmd == cmte_pkg::CMD_SCAN) begin
      cls.do_scan = (25'(in_start_word) < HW);
    end
  end

  assign in_full = (cnt_r == 2'(QD));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign take_ok = q_take && q_valid;
  assign q_word = q_r[rp_r];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (take_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(take_ok);
    end
  end
endmodule
`default_nettype wire

// ===== src/cmte_back.sv =====
// Back end: mark memory, summary memory, range walk and scan emitter with
// a two-entry result queue. Depends on cmte_pkg.
`default_nettype none
module cmte_back #(
  parameter int HEAP_WORDS        = 65536,
  parameter int SUMMARY_GROUP_LOG = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [30:0]       cfg_mirror_offset_words,
  input  wire logic              q_valid,
  input  cmte_pkg::cmd_word_t    q_word,
  output logic                   q_take,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_found,
  output logic [31:0]            out_word_address,
  output logic                   out_status,
  output logic                   out_last
);
  localparam int MW = HEAP_WORDS / 64;
  localparam int AW = $clog2(MW);
  localparam int SH = SUMMARY_GROUP_LOG - 6;
  localparam int GW = (AW > SH) ? AW - SH : 1;
  localparam int GC = MW >> SH;

  localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_WR = 3'd3,
                         S_SRD = 3'd4, S_LD = 3'd5, S_EMIT = 3'd6, S_ONE = 3'd7;

  logic [63:0]   mem [MW];
  logic          sum_mem [GC];
  logic [2:0]    st_r;
  cmte_pkg::cmd_word_t cw_r;
  logic [AW-1:0] w_r;
  logic [63:0]   rd_r, bits_r;
  logic          sf_r;
  logic          st1_r;
  logic [31:0]   base_r;

  // result queue
  logic [34:0] oq_r [2];
  logic [1:0]  ocnt_r;
  logic        owp_r, orp_r;
  logic        opush, opop;
  logic [34:0] odat;

  logic [AW-1:0] wlo, whi;
  logic [GW-1:0] gidx;
  logic [5:0]    b0, b1, bidx;
  logic [63:0]   mask, lowbit, rest;
  logic          room;
  logic          unused_ok;

  assign wlo = cw_r.lo[AW+5:6];
  assign whi = cw_r.hi[AW+5:6];
  // group of the current bitmap word
  assign gidx = GW'(w_r >> SH);
  assign b0 = (w_r == wlo) ? cw_r.lo[5:0] : 6'd0;
  assign b1 = (w_r == whi) ? cw_r.hi[5:0] : 6'd63;
  assign mask = ({64{1'b1}} >> (6'd63 - (b1 - b0))) << b0;
  assign lowbit = bits_r & (~bits_r + 64'd1);
  assign rest = bits_r & ~lowbit;
  assign room = (ocnt_r != 2'd2);

  always_comb begin
    bidx = '0;
    for (int i = 0; i < 64; i++) if (lowbit[i]) bidx = 6'(i);
  end

  assign q_take = (st_r == S_IDLE) && q_valid;

  // result pushes
  always_comb begin
    opush = 1'b0;
    odat = '0;
    if (st_r == S_ONE && room) begin
      opush = 1'b1;
      odat = {1'b0, 32'd0, st1_r, 1'b1};
    end else if (st_r == S_EMIT && room) begin
      opush = 1'b1;
      odat = {1'b1, base_r + 32'(bidx), 1'b0, (rest == 64'd0)};
    end
  end

  // mark and summary memories: one access a cycle, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if (st_r == S_RD || st_r == S_SRD) rd_r <= mem[w_r];
    if (st_r == S_SRD) sf_r <= sum_mem[gidx];
    if (st_r == S_INIT) begin
      mem[w_r] <= 64'd0;
      sum_mem[gidx] <= 1'b0;
    end else if (st_r == S_WR) begin
      mem[w_r] <= cw_r.set ? (rd_r | mask) : (rd_r & ~mask);
      sum_mem[gidx] <= cw_r.set;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      w_r <= '0;
      st1_r <= 1'b0;
      cw_r <= '0;
      bits_r <= '0;
      base_r <= '0;
    end else begin
      case (st_r)
        S_INIT: begin
          w_r <= w_r + AW'(1);
          if (w_r == AW'(MW - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cw_r <= q_word;
            st1_r <= q_word.err;
            w_r <= q_word.lo[AW+5:6];
            if (q_word.do_range) st_r <= S_RD;
            else if (q_word.do_scan) st_r <= S_SRD;
            else st_r <= S_ONE;
          end
        end
        S_RD: st_r <= S_WR;
        S_WR: begin
          if (w_r == whi) st_r <= S_ONE;
          else begin
            w_r <= w_r + AW'(1);
            st_r <= S_RD;
          end
        end
        S_SRD: st_r <= S_LD;
        S_LD: begin
          // skip the word when its group summary is clear
          bits_r <= rd_r;
          base_r <= {8'd0, cw_r.lo[23:6], 6'd0} +
                    (cw_r.reloc ? {1'b0, cfg_mirror_offset_words} : 32'd0);
          st_r <= (sf_r && rd_r != 64'd0) ? S_EMIT : S_ONE;
        end
        S_EMIT: begin
          if (room) begin
            bits_r <= rest;
            if (rest == 64'd0) st_r <= S_IDLE;
          end
        end
        S_ONE: if (room) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // output queue
  assign out_empty = (ocnt_r == 2'd0);
  assign opop = out_pop && !out_empty;
  assign {out_found, out_word_address, out_status, out_last} = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (opush) oq_r[owp_r] <= odat;
    if (!rst_n) begin
      ocnt_r <= '0; owp_r <= 1'b0; orp_r <= 1'b0;
    end else begin
      if (opush) owp_r <= ~owp_r;
      if (opop) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(opush) - 2'(opop);
    end
  end

  assign unused_ok = ^{cw_r.do_range, cw_r.do_scan, cw_r.err, cw_r.hi, cw_r.lo};
endmodule
`default_nettype wire

// ===== src/card_mark_table_engine.sv =====
// Top level of the card mark table engine: front classifier, back executor.
// Depends on cmte_pkg, cmte_front, cmte_back.
//
//   channel | ports                          | handshake
//   input   | in_cmd/start/end/relocating    | in_push, in_full
//   result  | out_found/word_address/...     | out_pop, out_empty
//   config  | cfg_mirror_offset_words        | cfg_we
//
// Mark/clear: each 64-word bitmap word in the range is read then written on one
// port (memory read then write), and the result follows the last write.
// Scan: the bitmap word is read (S_SRD) and loaded (S_LD), then one result per set bit.
// Start-after-end, out-of-heap and unused commands: S_IDLE hands them to S_ONE, which pushes the result.
// After reset a clearing pass over all HEAP_WORDS/64 bitmap words (1024 by default) zeroes
// marks and summaries; meanwhile two words queue and then in_full holds.
// Either queue stalls its side on its own; a full result queue halts the emitter.
`default_nettype none
module card_mark_table_engine #(
  parameter int HEAP_WORDS        = 65536,
  parameter int SUMMARY_GROUP_LOG = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_mirror_offset_words,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_start_word,
  input  wire logic [15:0] in_end_word,
  input  wire logic        in_relocating,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_found,
  output logic [31:0]      out_word_address,
  output logic             out_status,
  output logic             out_last
);
  logic [30:0] off_r;
  logic q_valid, q_take;
  cmte_pkg::cmd_word_t q_word;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) off_r <= '0;
    else if (cfg_we) off_r <= cfg_mirror_offset_words;
  end

  cmte_front #(.HEAP_WORDS(HEAP_WORDS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_cmd, .in_start_word, .in_end_word,
    .in_relocating, .q_valid, .q_word, .q_take);

  cmte_back #(.HEAP_WORDS(HEAP_WORDS), .SUMMARY_GROUP_LOG(SUMMARY_GROUP_LOG)) u_back (
    .clk, .rst_n, .cfg_mirror_offset_words(off_r), .q_valid, .q_word, .q_take,
    .out_empty, .out_pop, .out_found, .out_word_address, .out_status, .out_last);
endmodule
`default_nettype wire

// ===== src/cmte_checker.sv =====
// Port-level checker for the card mark table engine, bound to the top level.
// Depends on card_mark_table_engine_macros.svh.
`default_nettype none
`include "card_mark_table_engine_macros.svh"
module cmte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic        out_found,
  input wire logic [31:0] out_word_address,
  input wire logic        out_status,
  input wire logic        out_last
);
  `CMTE_ASSERT(a_miss_last, clk, rst_n, (!out_empty && !out_found) |-> out_last, "miss not last")
  `CMTE_ASSERT(a_miss_zero, clk, rst_n, (!out_empty && !out_found) |-> (out_word_address == 32'd0), "miss addr")
  `CMTE_ASSERT(a_hit_ok, clk, rst_n, (!out_empty && out_found) |-> !out_status, "hit status")
  `CMTE_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> out_empty, "not empty after reset")
endmodule
bind card_mark_table_engine cmte_checker u_chk (.*);
`default_nettype wire
